// ----- rtl/spf_pkg.sv -----
// shared types and constants for the stream pattern finder
// no dependencies; imported by every module of the block but spf_ram
`default_nettype none

package spf_pkg;

  localparam int unsigned MaxNeedle = 256;
  localparam int unsigned AddrW     = $clog2(MaxNeedle);
  localparam int unsigned LenW      = AddrW + 1;
  localparam int unsigned PosW      = 32;
  localparam int unsigned ByteW     = 8;

  typedef enum logic [1:0] {
    OpLoad  = 2'd0,
    OpByte  = 2'd1,
    OpEnd   = 2'd2,
    OpClear = 2'd3
  } op_e;

  // controller to datapath
  typedef struct packed {
    logic load;       // append needle byte
    logic shift;      // take in haystack byte
    logic rearm;      // end of stream
    logic clear;      // drop needle
    logic cmp_start;  // reset compare walk
    logic cmp_run;    // compare walk step
    logic push;       // load result register
    logic found;      // kind of pushed result
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic win_ok;     // incoming byte completes a testable window
    logic reported;   // match already reported in this stream
    logic cmp_match;  // whole needle compared equal
    logic cmp_miss;   // mismatch seen
    logic out_free;   // result register can take a word
  } sts_t;

endpackage

`default_nettype wire

// ----- rtl/stream_pattern_finder.sv -----
// top level of the stream pattern finder: stream ports, controller and datapath
// depends on spf_pkg, spf_ctrl, spf_dp and spf_ram
`default_nettype none

// Finds the first offset in a byte stream at which a stored needle (up to
// 256 bytes) appears whole. Each input word carries a kind in tuser: load
// appends a needle byte, byte shifts in a haystack byte, end closes the
// stream (reporting not-found if nothing matched) and rearms, clear drops the
// needle. At most one match is reported per stream, with the offset of its
// first byte; the position count saturates at all ones. Load, clear and an
// end with nothing to report need only the idle state; an end that reports
// also passes through the report state. A haystack byte needs no compare
// while the needle is empty, the stream is too short for it or a match was
// already reported; otherwise needle and byte history sit in two 256-entry
// rams and are compared one byte per cycle, taking no new word meanwhile. A
// match word waits in the output register; a new word is accepted while it
// waits, and only a second result stalls until the first is taken.

module stream_pattern_finder (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  wire logic [1:0]  s_axis_tuser,   // [1:0] op
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [31:0]      m_axis_tdata,   // [31:0] match_offset
  output logic             m_axis_tuser    // [0] match_found
);

  import spf_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // controller owns the input handshake and sequences each word
  spf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_op_i    (s_axis_tuser),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // datapath holds needle, history, position and the result register
  spf_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_byte_i    (s_axis_tdata),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .out_ready_i  (m_axis_tready),
    .out_valid_o  (m_axis_tvalid),
    .out_found_o  (m_axis_tuser),
    .out_offset_o (m_axis_tdata)
  );

endmodule

`default_nettype wire

// ----- rtl/spf_ram.sv -----
// generic simple dual-port ram, one write and one registered read port
// no dependencies
`default_nettype none

module spf_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256
) (
  input  wire logic                                      clk_i,
  input  wire logic                                      we_i,
  input  wire logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  wire logic [Width-1:0]                          wdata_i,
  input  wire logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic      [Width-1:0]                          rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// ----- rtl/spf_ctrl.sv -----
// controller state machine: input handshake, compare sequencing, result posting
// depends on spf_pkg
`default_nettype none

module spf_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  input  wire logic [1:0]    in_op_i,
  output logic               in_ready_o,
  input  wire spf_pkg::sts_t sts_i,
  output spf_pkg::cmd_t      cmd_o
);

  import spf_pkg::*;

  typedef enum logic [2:0] {
    StIdle   = 3'b001,
    StCmp    = 3'b010,
    StReport = 3'b100
  } state_e;

  state_e state_q, state_d;
  logic   found_q, found_d;
  op_e    op;

  assign op         = op_e'(in_op_i);
  assign in_ready_o = (state_q == StIdle);

  always_comb begin
    state_d = state_q;
    found_d = found_q;
    cmd_o   = '0;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          unique case (op)
            OpLoad: cmd_o.load = 1'b1;
            OpByte: begin
              cmd_o.shift = 1'b1;
              if (sts_i.win_ok) begin
                cmd_o.cmp_start = 1'b1;
                state_d         = StCmp;
              end
            end
            OpEnd: begin
              cmd_o.rearm = 1'b1;
              if (!sts_i.reported) begin
                found_d = 1'b0;
                state_d = StReport;
              end
            end
            OpClear: cmd_o.clear = 1'b1;
            default: cmd_o.clear = 1'b1;
          endcase
        end
      end
      StCmp: begin
        cmd_o.cmp_run = 1'b1;
        priority if (sts_i.cmp_miss) begin
          state_d = StIdle;
        end else if (sts_i.cmp_match) begin
          found_d = 1'b1;
          state_d = StReport;
        end
      end
      StReport: begin
        if (sts_i.out_free) begin
          cmd_o.push  = 1'b1;
          cmd_o.found = found_q;
          state_d     = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      found_q <= 1'b0;
    end else begin
      state_q <= state_d;
      found_q <= found_d;
    end
  end

  // a result is only posted when the output register can take it
  a_push_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.push |-> sts_i.out_free) else $error("push into busy result register");

  // a compare walk always follows a haystack byte
  a_cmp_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(state_q == StCmp) |-> $past(cmd_o.shift && sts_i.win_ok))
    else $error("compare entered without a haystack byte");

  // no item taken while the walk or a pending report is in progress
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != StIdle) |-> !(cmd_o.load || cmd_o.shift || cmd_o.rearm || cmd_o.clear))
    else $error("item taken while busy");

endmodule

`default_nettype wire

// ----- rtl/spf_dp.sv -----
// datapath: needle and history rams, position counter, compare walk, result register
// depends on spf_pkg and spf_ram
`default_nettype none

module spf_dp (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic [spf_pkg::ByteW-1:0]   in_byte_i,
  input  wire spf_pkg::cmd_t               cmd_i,
  output spf_pkg::sts_t                    sts_o,
  input  wire logic                        out_ready_i,
  output logic                             out_valid_o,
  output logic                             out_found_o,
  output logic [spf_pkg::PosW-1:0]         out_offset_o
);

  import spf_pkg::*;

  logic [LenW-1:0]  len_q, len_d;
  logic [PosW-1:0]  pos_q, pos_d, pos_inc;
  logic             rep_q, rep_d;
  logic [AddrW-1:0] wp_q, wp_d;
  logic [AddrW-1:0] base_q, base_d;
  logic [LenW-1:0]  rd_idx_q, rd_idx_d;
  logic             rd_vld_q, rd_vld_d;
  logic             last_q, last_d;
  logic             ovalid_q, ovalid_d;
  logic             ofound_q, ofound_d;
  logic [PosW-1:0]  ooff_q, ooff_d;

  logic [ByteW-1:0] ndl_rdata, hist_rdata;
  logic [AddrW-1:0] hist_raddr;
  logic             ndl_we, issue;

  assign pos_inc = (pos_q == '1) ? pos_q : pos_q + PosW'(1);
  assign ndl_we  = cmd_i.load && (len_q < LenW'(MaxNeedle));
  assign issue   = cmd_i.cmp_run && (rd_idx_q < len_q);

  assign hist_raddr = base_q + rd_idx_q[AddrW-1:0];

  spf_ram #(.Width(ByteW), .Depth(MaxNeedle)) u_needle (
    .clk_i   (clk_i),
    .we_i    (ndl_we),
    .waddr_i (len_q[AddrW-1:0]),
    .wdata_i (in_byte_i),
    .raddr_i (rd_idx_q[AddrW-1:0]),
    .rdata_o (ndl_rdata)
  );

  // circular history, newest byte at wp_q - 1
  spf_ram #(.Width(ByteW), .Depth(MaxNeedle)) u_hist (
    .clk_i   (clk_i),
    .we_i    (cmd_i.shift),
    .waddr_i (wp_q),
    .wdata_i (in_byte_i),
    .raddr_i (hist_raddr),
    .rdata_o (hist_rdata)
  );

  always_comb begin
    sts_o.win_ok    = !rep_q && (len_q != '0) && (pos_inc >= PosW'(len_q));
    sts_o.reported  = rep_q;
    sts_o.cmp_miss  = rd_vld_q && (ndl_rdata != hist_rdata);
    sts_o.cmp_match = rd_vld_q && last_q && (ndl_rdata == hist_rdata);
    sts_o.out_free  = !ovalid_q || out_ready_i;
  end

  always_comb begin
    len_d    = len_q;
    pos_d    = pos_q;
    rep_d    = rep_q;
    wp_d     = wp_q;
    base_d   = base_q;
    rd_idx_d = rd_idx_q;
    rd_vld_d = 1'b0;
    last_d   = 1'b0;
    ovalid_d = ovalid_q;
    ofound_d = ofound_q;
    ooff_d   = ooff_q;

    if (ndl_we) begin
      len_d = len_q + LenW'(1);
    end
    if (cmd_i.clear) begin
      len_d = '0;
    end
    if (cmd_i.shift) begin
      pos_d  = pos_inc;
      wp_d   = wp_q + AddrW'(1);
      // oldest byte of the window; a full-depth needle wraps to wp_q + 1
      base_d = wp_q - len_q[AddrW-1:0] + AddrW'(1);
    end
    if (cmd_i.rearm) begin
      pos_d = '0;
      rep_d = 1'b0;
    end
    if (cmd_i.cmp_start) begin
      rd_idx_d = '0;
    end else if (issue) begin
      rd_idx_d = rd_idx_q + LenW'(1);
      rd_vld_d = 1'b1;
      last_d   = (rd_idx_q == len_q - LenW'(1));
    end
    if (cmd_i.push) begin
      ovalid_d = 1'b1;
      ofound_d = cmd_i.found;
      ooff_d   = cmd_i.found ? (pos_q - PosW'(len_q)) : '0;
      if (cmd_i.found) begin
        rep_d = 1'b1;
      end
    end else if (out_ready_i) begin
      ovalid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q    <= '0;
      pos_q    <= '0;
      rep_q    <= 1'b0;
      wp_q     <= '0;
      rd_vld_q <= 1'b0;
      ovalid_q <= 1'b0;
    end else begin
      len_q    <= len_d;
      pos_q    <= pos_d;
      rep_q    <= rep_d;
      wp_q     <= wp_d;
      rd_vld_q <= rd_vld_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    base_q   <= base_d;
    rd_idx_q <= rd_idx_d;
    last_q   <= last_d;
    ofound_q <= ofound_d;
    ooff_q   <= ooff_d;
  end

  assign out_valid_o  = ovalid_q;
  assign out_found_o  = ofound_q;
  assign out_offset_o = ooff_q;

  a_len_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_q <= LenW'(MaxNeedle)) else $error("needle length past capacity");

  // the reported flag only sets together with a found result
  a_rep_set: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rep_q) |-> $past(cmd_i.push && cmd_i.found))
    else $error("reported flag set without a match result");

  a_cmp_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(sts_o.cmp_match && sts_o.cmp_miss)) else $error("match and miss together");

endmodule

`default_nettype wire

// ----- dv/spf_checker.sv -----
// result checker for stream_pattern_finder: watches both stream ports,
// predicts the reported match words and compares them in order
// depends on spf_pkg
module spf_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [7:0]  in_data_i,
  input  logic [1:0]  in_kind_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [31:0] out_offset_i,
  input  logic        out_found_i,
  output int          fail_count_o,
  output int          pending_o
);

  timeunit 1ns;
  timeprecision 1ps;

  import spf_pkg::*;

  typedef struct packed {
    logic            found;
    logic [PosW-1:0] offset;
  } match_report_t;

  logic [ByteW-1:0] needle_mem [MaxNeedle];
  logic [ByteW-1:0] history    [MaxNeedle];  // entry 0 newest
  int unsigned      needle_len;
  logic [PosW-1:0]  stream_pos;
  logic             reported;
  match_report_t    reports_q [$];
  int               fails;

  always @(posedge clk_i or negedge rst_ni) begin : search_model
    match_report_t want;
    op_e           op;
    bit            hit;
    if (!rst_ni) begin
      for (int i = 0; i < MaxNeedle; i++) begin
        needle_mem[i] = '0;
        history[i]    = '0;
      end
      needle_len = 0;
      stream_pos = '0;
      reported   = 1'b0;
      reports_q.delete();
      fails = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      // result side first: a word leaving now belongs to an older input word
      if (out_valid_i && out_ready_i) begin
        if (reports_q.size() == 0) begin
          $error("unexpected result word: match_found %0d, match_offset %0d",
                 out_found_i, out_offset_i);
          fails++;
        end else begin
          want = reports_q.pop_front();
          if (out_found_i !== want.found) begin
            $error("match_found: expected %0d, got %0d", want.found, out_found_i);
            fails++;
          end
          if (out_offset_i !== want.offset) begin
            $error("match_offset: expected %0d, got %0d", want.offset, out_offset_i);
            fails++;
          end
        end
      end

      if (in_valid_i && in_ready_i) begin
        op = op_e'(in_kind_i);
        case (op)
          OpLoad: begin
            // loads past a full needle are dropped
            if (needle_len < MaxNeedle) begin
              needle_mem[needle_len] = in_data_i;
              needle_len++;
            end
          end
          OpByte: begin
            for (int i = MaxNeedle - 1; i > 0; i--) history[i] = history[i-1];
            history[0] = in_data_i;
            if (stream_pos != '1) stream_pos++;
            if (!reported) begin
              // only a window that is fully filled with stream bytes counts
              hit = (needle_len != 0) && (stream_pos >= needle_len);
              for (int i = 0; i < needle_len; i++) begin
                if (needle_mem[i] != history[needle_len-1-i]) hit = 1'b0;
              end
              if (hit) begin
                reported = 1'b1;
                reports_q.push_back('{found: 1'b1, offset: stream_pos - needle_len});
              end
            end
          end
          OpEnd: begin
            if (!reported) reports_q.push_back('{found: 1'b0, offset: '0});
            reported   = 1'b0;
            stream_pos = '0;
            for (int i = 0; i < MaxNeedle; i++) history[i] = '0;
          end
          default: needle_len = 0;
        endcase
      end

      fail_count_o <= fails;
      pending_o    <= reports_q.size();
    end
  end

endmodule

// ----- dv/tb.sv -----
// testbench top for stream_pattern_finder: clock, reset, stimulus and verdict
// depends on spf_pkg, spf_checker and the block's rtl
module tb;

  timeunit 1ns;
  timeprecision 1ps;

  import spf_pkg::*;

  localparam int unsigned StallLimit = 4000;  // cycles with no word moving
  localparam int unsigned TailCycles = 600;   // covers a full-needle compare walk
  localparam int unsigned ItemTarget = 1000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;

  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;   // [7:0] data_byte
  logic [1:0]  s_axis_tuser = '0;   // [1:0] op
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;        // [31:0] match_offset
  logic        m_axis_tuser;        // [0] match_found

  int          fail_count;
  int          pending_count;
  int unsigned stall_cycles = 0;
  int unsigned sent = 0;
  logic        calm = 1'b0;         // high: neither side idles

  // shadow of the loaded needle, only used to plant matches in the stream
  logic [7:0]  needle_copy [$];

  always #6 clk_i = ~clk_i;

  stream_pattern_finder u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  spf_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_i   (s_axis_tready),
    .in_data_i    (s_axis_tdata),
    .in_kind_i    (s_axis_tuser),
    .out_valid_i  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_offset_i (m_axis_tdata),
    .out_found_i  (m_axis_tuser),
    .fail_count_o (fail_count),
    .pending_o    (pending_count)
  );

  // result side backpressure, off during the calm stretch
  always @(posedge clk_i) begin
    m_axis_tready <= calm || ($urandom_range(99) >= 28);
  end

  // watchdog: count cycles in which no word moves on either port
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= StallLimit) begin
      $display("stream_pattern_finder: mismatch");
      $finish;
    end
  end

  // drive one word and hold it until taken; valid stays high into the
  // next word unless an idle gap is drawn
  task automatic send_word(op_e op, logic [7:0] b);
    while (!calm && $urandom_range(99) < 28) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= b;
    do @(posedge clk_i); while (!s_axis_tready);
    sent++;
    if (op == OpLoad && needle_copy.size() < MaxNeedle) needle_copy.push_back(b);
    else if (op == OpClear) needle_copy.delete();
  endtask

  // one stream: mostly a fresh needle, a stream that may hold it, then end;
  // sometimes plain noise or a broken sequence
  task automatic run_stream(bit full_needle);
    int unsigned len;
    logic [7:0]  mask;
    logic [7:0]  plant [$];
    if (!full_needle && $urandom_range(99) < 15) begin
      repeat ($urandom_range(1, 8)) send_word(op_e'($urandom_range(3)), 8'($urandom));
      return;
    end
    // a narrow alphabet gives plenty of near misses and accidental matches
    mask = ($urandom_range(1) == 0) ? 8'h03 : 8'hFF;
    if (full_needle) len = $urandom_range(MaxNeedle, MaxNeedle + 4);
    else if ($urandom_range(99) < 8) len = $urandom_range(9, 40);
    else len = $urandom_range(0, 6);
    if (full_needle || $urandom_range(99) < 85) send_word(OpClear, 8'($urandom));
    repeat (len) send_word(OpLoad, 8'($urandom) & mask);
    repeat ($urandom_range(0, 12)) send_word(OpByte, 8'($urandom) & mask);
    // needle edited while the stream runs
    if ($urandom_range(99) < 6) begin
      send_word(($urandom_range(1) == 0) ? OpClear : OpLoad, 8'($urandom) & mask);
    end
    if (full_needle || $urandom_range(99) < 70) begin
      plant = needle_copy;
      foreach (plant[i]) send_word(OpByte, plant[i]);
    end
    repeat ($urandom_range(0, 8)) send_word(OpByte, 8'($urandom) & mask);
    if ($urandom_range(99) < 90) send_word(OpEnd, 8'($urandom));
  endtask

  initial begin
    bit full_done;
    full_done = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty needle: end with no stream, a byte, end with a stream
    send_word(OpEnd,   8'h00);
    send_word(OpByte,  8'hFF);
    send_word(OpEnd,   8'hA5);
    // needle 00 ff; the first ff alone would hit the zero history
    send_word(OpLoad,  8'h00);
    send_word(OpLoad,  8'hFF);
    send_word(OpByte,  8'hFF);
    send_word(OpByte,  8'h00);
    send_word(OpByte,  8'hFF);
    // already reported: silent bytes, silent end
    send_word(OpByte,  8'h00);
    send_word(OpByte,  8'hFF);
    send_word(OpEnd,   8'h00);
    // clear and rebuild the needle mid-stream, history kept
    send_word(OpByte,  8'h00);
    send_word(OpClear, 8'h5A);
    send_word(OpLoad,  8'h00);
    send_word(OpByte,  8'h11);
    send_word(OpLoad,  8'h11);
    send_word(OpByte,  8'h7F);
    send_word(OpByte,  8'h00);
    send_word(OpByte,  8'h11);
    send_word(OpEnd,   8'hFF);
    // needle present but the stream is empty
    send_word(OpEnd,   8'h00);
    send_word(OpClear, 8'hFF);

    // random streams, with a stretch of no idling in the middle;
    // one stream uses a full needle plus up to four loads past the end
    while (sent < ItemTarget) begin
      calm <= (sent >= 300 && sent < 600);
      run_stream(!full_done && sent >= 350);
      if (sent >= 350) full_done = 1'b1;
    end
    s_axis_tvalid <= 1'b0;

    @(posedge clk_i);
    while (pending_count != 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);

    if (fail_count == 0 && pending_count == 0) begin
      $display("stream_pattern_finder: match");
    end else begin
      $display("stream_pattern_finder: mismatch");
    end
    $finish;
  end

endmodule
